/* rtl/hard_disk_placement_cell_list_defines.svh */
// assertion macros shared by the disk placement rtl
`ifndef HARD_DISK_PLACEMENT_CELL_LIST_DEFINES_SVH
`define HARD_DISK_PLACEMENT_CELL_LIST_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define HDPCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HDPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hdpcl_pkg.sv */
// package with field widths, codes and sequencer states of the disk placement block
`timescale 1ns / 1ps
package hdpcl_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned DIDX_W     = 12;
  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CNT_CFG_W  = 7;
  localparam int unsigned TGT_CFG_W  = 13;

  typedef enum logic [STATUS_W-1:0] {
    STAT_PLACED   = 3'd0,
    STAT_OVERLAP  = 3'd1,
    STAT_GAVE_UP  = 3'd2,
    STAT_FINISHED = 3'd3,
    STAT_CELLFULL = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH    = 3'd0,
    REG_BOX_HEIGHT   = 3'd1,
    REG_CELL_SIZE    = 3'd2,
    REG_CELLS_ACROSS = 3'd3,
    REG_CELLS_DOWN   = 3'd4,
    REG_DIAMETER     = 3'd5,
    REG_TARGET       = 3'd6,
    REG_ATTEMPTS     = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIVX, ST_DIVY, ST_DIAM, ST_NBR, ST_FILL,
    ST_MEMBER, ST_MEMW, ST_POS, ST_WDX, ST_WDY, ST_SQX, ST_SQY, ST_NEXT,
    ST_OWN, ST_OWNW, ST_INSERT, ST_OUT
  } state_e;

endpackage

/* rtl/hdpcl_if.sv */
// handshake channel interfaces: proposals in, results out, register writes
`timescale 1ns / 1ps
interface hdpcl_in_if;
  import hdpcl_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

interface hdpcl_out_if;
  import hdpcl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DIDX_W-1:0]   disk_index;
  logic [TOTAL_W-1:0]  placed_total;
  modport source (output valid, status, disk_index, placed_total, input ready);
  modport sink   (input valid, status, disk_index, placed_total, output ready);
endinterface

interface hdpcl_cfg_if;
  import hdpcl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/hdpcl_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module hdpcl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/hdpcl_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hdpcl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d, den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q[31:0], quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[31:0];
endmodule

/* rtl/hard_disk_placement_cell_list.sv */
// top level: hard disk placement by sequential addition over a cell list
// steps: after acceptance two divider passes find the cell, then each neighbor cell is looked up
//   and each stored disk in it is tested with two more divider passes and two multiplies;
//   then a free disk is inserted and the result emitted; finished or given-up proposals skip the divider
// one proposal at a time, paced by the shared divider
// reset: config to defaults; a clearing pass over all MAX_CELLS_X*MAX_CELLS_Y cells zeroes
//   the cell fill ram, no proposal is taken meanwhile
`timescale 1ns / 1ps
`include "hard_disk_placement_cell_list_defines.svh"
module hard_disk_placement_cell_list #(
  parameter int unsigned MAX_DISKS     = 4096,
  parameter int unsigned CELL_CAPACITY = 8,
  parameter int unsigned MAX_CELLS_X   = 64,
  parameter int unsigned MAX_CELLS_Y   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hdpcl_in_if.sink     in_ch,
  hdpcl_out_if.source  out_ch,
  hdpcl_cfg_if.sink    cfg_ch
);
  import hdpcl_pkg::*;

  localparam int unsigned NCELLS = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int unsigned NMEM   = NCELLS * CELL_CAPACITY;
  localparam int unsigned IDX_W  = MAX_DISKS > 1 ? $clog2(MAX_DISKS) : 1;
  localparam int unsigned PC_W   = $clog2(MAX_DISKS + 1);
  localparam int unsigned CELL_W = $clog2(NCELLS);
  localparam int unsigned MEM_W  = $clog2(NMEM);
  localparam int unsigned FILL_W = $clog2(CELL_CAPACITY + 1);
  localparam int unsigned CX_W   = $clog2(MAX_CELLS_X);
  localparam int unsigned CY_W   = $clog2(MAX_CELLS_Y);
  localparam int unsigned NX_W   = $clog2(MAX_CELLS_X + 1);
  localparam int unsigned NY_W   = $clog2(MAX_CELLS_Y + 1);

  state_e state_q, state_d;

  logic [31:0]          bw_q, bh_q, cs_q, dd_q, al_q;
  logic [CNT_CFG_W-1:0] ca_q, cd_q;
  logic [TGT_CFG_W-1:0] tc_q;

  logic [PC_W-1:0]   placed_q, placed_d;
  logic [31:0]       fail_q, fail_d;
  logic              fin_q, fin_d;
  logic [CELL_W:0]   clr_q, clr_d;
  logic              ovalid_q, ovalid_d;
  status_e           ostat_q, ostat_d, rstat_q, rstat_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d, ridx_q, ridx_d;
  logic [PC_W-1:0]   otot_q, otot_d;

  logic [31:0]       px_q, px_d, py_q, py_d, sy_q, sy_d, ax_q, ax_d;
  logic              neg_q, neg_d;
  logic [NX_W-1:0]   nx_q, nx_d;
  logic [NY_W-1:0]   ny_q, ny_d;
  logic [CX_W-1:0]   cx_q, cx_d;
  logic [CY_W-1:0]   cy_q, cy_d;
  logic [1:0]        a_q, a_d, b_q, b_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [FILL_W-1:0] cnt_q, cnt_d, i_q, i_d, ofill_q, ofill_d;
  logic [63:0]       diam2_q, diam2_d, sqx_q, sqx_d;

  // shared arithmetic
  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo, div_rem;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // memories
  logic              fill_we;
  logic [CELL_W-1:0] fill_waddr, fill_raddr;
  logic [FILL_W-1:0] fill_wdata, fill_rdata;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_waddr, mem_raddr;
  logic [IDX_W-1:0]  mem_rdata;
  logic              pos_we;
  logic [IDX_W-1:0]  pos_raddr;
  logic [31:0]       sx_rdata, sy_rdata;

  logic [31:0]       cs_eff, bw_eff, bh_eff, tgt_eff, gx, gy, r_wrap;
  logic [32:0]       dx, dy;
  logic [CELL_W-1:0] own_cell, nbr_cell;
  logic              last_cell, fin_now;

  hdpcl_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  hdpcl_ram #(.WIDTH(FILL_W), .DEPTH(NCELLS)) u_fill_ram (
    .clk_i, .we_i(fill_we), .waddr_i(fill_waddr), .wdata_i(fill_wdata),
    .raddr_i(fill_raddr), .rdata_o(fill_rdata)
  );

  hdpcl_ram #(.WIDTH(IDX_W), .DEPTH(NMEM)) u_member_ram (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(placed_q[IDX_W-1:0]),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  hdpcl_ram #(.WIDTH(32), .DEPTH(MAX_DISKS)) u_x_ram (
    .clk_i, .we_i(pos_we), .waddr_i(placed_q[IDX_W-1:0]), .wdata_i(px_q),
    .raddr_i(pos_raddr), .rdata_o(sx_rdata)
  );

  hdpcl_ram #(.WIDTH(32), .DEPTH(MAX_DISKS)) u_y_ram (
    .clk_i, .we_i(pos_we), .waddr_i(placed_q[IDX_W-1:0]), .wdata_i(py_q),
    .raddr_i(pos_raddr), .rdata_o(sy_rdata)
  );

  assign cs_eff  = (cs_q == '0) ? 32'd1 : cs_q;
  assign bw_eff  = (bw_q == '0) ? 32'd1 : bw_q;
  assign bh_eff  = (bh_q == '0) ? 32'd1 : bh_q;
  assign tgt_eff = (32'(tc_q) > 32'(MAX_DISKS)) ? 32'(MAX_DISKS) : 32'(tc_q);
  assign fin_now = fin_q || (32'(placed_q) >= tgt_eff);
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign dx      = {1'b0, px_q} - {1'b0, sx_rdata};
  assign dy      = {1'b0, py_q} - {1'b0, sy_q};

  // neighbor cell with periodic wrap
  always_comb begin
    case (a_q)
      2'd0:    gx = (cx_q == '0) ? 32'(nx_q) - 32'd1 : 32'(cx_q) - 32'd1;
      2'd1:    gx = 32'(cx_q);
      default: gx = (32'(cx_q) + 32'd1 == 32'(nx_q)) ? 32'd0 : 32'(cx_q) + 32'd1;
    endcase
    case (b_q)
      2'd0:    gy = (cy_q == '0) ? 32'(ny_q) - 32'd1 : 32'(cy_q) - 32'd1;
      2'd1:    gy = 32'(cy_q);
      default: gy = (32'(cy_q) + 32'd1 == 32'(ny_q)) ? 32'd0 : 32'(cy_q) + 32'd1;
    endcase
  end

  assign nbr_cell  = CELL_W'(gy * 32'(MAX_CELLS_X) + gx);
  assign own_cell  = CELL_W'(32'(cy_q) * 32'(MAX_CELLS_X) + 32'(cx_q));
  assign last_cell = (a_q == 2'd2) && (b_q == 2'd2);

  // remainder into [0, L), negative differences folded back, then the nearer image taken, in [0, L/2]
  always_comb begin
    logic [31:0] len;
    logic [31:0] r;
    len = (state_q == ST_WDX) ? bw_eff : bh_eff;
    r   = (neg_q && div_rem != '0) ? len - div_rem : div_rem;
    r_wrap = ({r, 1'b0} > {1'b0, len}) ? len - r : r;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == (CELL_W+1)'(NCELLS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_ch.valid) state_d = ST_CHECK;
      ST_CHECK:  state_d = (fin_now || fail_q > al_q) ? ST_OUT : ST_DIVX;
      ST_DIVX:   if (div_done) state_d = ST_DIVY;
      ST_DIVY:   if (div_done) state_d = ST_DIAM;
      ST_DIAM:   state_d = ST_NBR;
      ST_NBR:    state_d = ST_FILL;
      ST_FILL:   state_d = (fill_rdata != '0) ? ST_MEMBER : (last_cell ? ST_OWN : ST_NBR);
      ST_MEMBER: state_d = ST_MEMW;
      ST_MEMW:   state_d = (32'(mem_rdata) < 32'(MAX_DISKS)) ? ST_POS : ST_NEXT;
      ST_POS:    state_d = ST_WDX;
      ST_WDX:    if (div_done) state_d = ST_WDY;
      ST_WDY:    if (div_done) state_d = ST_SQX;
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = (sqx_q + mul_p < diam2_q) ? ST_OUT : ST_NEXT;
      ST_NEXT: begin
        if (i_q + FILL_W'(1) < cnt_q) state_d = ST_MEMBER;
        else if (last_cell)           state_d = ST_OWN;
        else                          state_d = ST_NBR;
      end
      ST_OWN:    state_d = ST_OWNW;
      ST_OWNW:   state_d = (32'(fill_rdata) >= 32'(CELL_CAPACITY)) ? ST_OUT : ST_INSERT;
      ST_INSERT: state_d = ST_OUT;
      ST_OUT:    if (!ovalid_q || out_ch.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    placed_d = placed_q;  fail_d = fail_q;  fin_d = fin_q;  clr_d = clr_q;
    ovalid_d = ovalid_q;  ostat_d = ostat_q;  oidx_d = oidx_q;  otot_d = otot_q;
    rstat_d = rstat_q;  ridx_d = ridx_q;
    px_d = px_q;  py_d = py_q;  sy_d = sy_q;  ax_d = ax_q;  neg_d = neg_q;
    nx_d = nx_q;  ny_d = ny_q;  cx_d = cx_q;  cy_d = cy_q;  a_d = a_q;  b_d = b_q;
    cell_d = cell_q;  cnt_d = cnt_q;  i_d = i_q;  ofill_d = ofill_q;
    diam2_d = diam2_q;  sqx_d = sqx_q;
    div_start = 1'b0;  div_num = px_q;  div_den = cs_eff;
    mul_a = dd_q;  mul_b = dd_q;
    fill_we = 1'b0;  fill_waddr = own_cell;  fill_wdata = ofill_q + FILL_W'(1);
    fill_raddr = own_cell;
    mem_we = 1'b0;
    mem_waddr = MEM_W'(32'(own_cell) * 32'(CELL_CAPACITY) + 32'(ofill_q));
    mem_raddr = MEM_W'(32'(cell_q) * 32'(CELL_CAPACITY) + 32'(i_q));
    pos_we = 1'b0;  pos_raddr = mem_rdata;

    if (ovalid_q && out_ch.ready) ovalid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q[CELL_W-1:0];
        fill_wdata = '0;
        clr_d      = clr_q + (CELL_W+1)'(1);
      end
      ST_IDLE: begin
        px_d = in_ch.pos_x;
        py_d = in_ch.pos_y;
        nx_d = (ca_q == '0) ? NX_W'(1) :
               (32'(ca_q) > 32'(MAX_CELLS_X)) ? NX_W'(MAX_CELLS_X) : NX_W'(ca_q);
        ny_d = (cd_q == '0) ? NY_W'(1) :
               (32'(cd_q) > 32'(MAX_CELLS_Y)) ? NY_W'(MAX_CELLS_Y) : NY_W'(cd_q);
      end
      ST_CHECK: begin
        ridx_d = '0;
        if (fin_now) begin
          fin_d   = 1'b1;
          rstat_d = STAT_FINISHED;
        end else if (fail_q > al_q) begin
          fin_d   = 1'b1;
          rstat_d = STAT_GAVE_UP;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          cx_d = (div_quo >= 32'(nx_q)) ? CX_W'(32'(nx_q) - 32'd1) : CX_W'(div_quo);
          div_start = 1'b1;
          div_num   = py_q;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          cy_d = (div_quo >= 32'(ny_q)) ? CY_W'(32'(ny_q) - 32'd1) : CY_W'(div_quo);
        end
      end
      ST_DIAM: begin
        diam2_d = mul_p;
        a_d = 2'd0;
        b_d = 2'd0;
      end
      ST_NBR: begin
        fill_raddr = nbr_cell;
        cell_d     = nbr_cell;
      end
      ST_FILL: begin
        cnt_d = fill_rdata;
        i_d   = '0;
        if (fill_rdata == '0 && !last_cell) begin
          if (b_q == 2'd2) begin
            a_d = a_q + 2'd1;
            b_d = 2'd0;
          end else begin
            b_d = b_q + 2'd1;
          end
        end
      end
      ST_POS: begin
        sy_d      = sy_rdata;
        neg_d     = dx[32];
        div_start = 1'b1;
        div_num   = dx[32] ? 32'(-dx) : dx[31:0];
        div_den   = bw_eff;
      end
      ST_WDX: begin
        if (div_done) begin
          ax_d      = r_wrap;
          neg_d     = dy[32];
          div_start = 1'b1;
          div_num   = dy[32] ? 32'(-dy) : dy[31:0];
          div_den   = bh_eff;
        end
      end
      ST_WDY: begin
        if (div_done) sy_d = r_wrap;
      end
      ST_SQX: begin
        mul_a = ax_q;
        mul_b = ax_q;
        sqx_d = mul_p;
      end
      ST_SQY: begin
        mul_a = sy_q;
        mul_b = sy_q;
        if (sqx_q + mul_p < diam2_q) begin
          rstat_d = STAT_OVERLAP;
          ridx_d  = '0;
          fail_d  = (fail_q == '1) ? fail_q : fail_q + 32'd1;
        end
      end
      ST_NEXT: begin
        if (i_q + FILL_W'(1) < cnt_q) begin
          i_d = i_q + FILL_W'(1);
        end else if (!last_cell) begin
          if (b_q == 2'd2) begin
            a_d = a_q + 2'd1;
            b_d = 2'd0;
          end else begin
            b_d = b_q + 2'd1;
          end
        end
      end
      ST_OWNW: begin
        ofill_d = fill_rdata;
        ridx_d  = '0;
        if (32'(fill_rdata) >= 32'(CELL_CAPACITY)) begin
          rstat_d = STAT_CELLFULL;
          fail_d  = (fail_q == '1) ? fail_q : fail_q + 32'd1;
        end
      end
      ST_INSERT: begin
        fill_we  = 1'b1;
        mem_we   = 1'b1;
        pos_we   = 1'b1;
        rstat_d  = STAT_PLACED;
        ridx_d   = placed_q[IDX_W-1:0];
        placed_d = placed_q + PC_W'(1);
        fail_d   = '0;
        if (32'(placed_q) + 32'd1 >= tgt_eff) fin_d = 1'b1;
      end
      ST_OUT: begin
        if (!ovalid_q || out_ch.ready) begin
          ovalid_d = 1'b1;
          ostat_d  = rstat_q;
          oidx_d   = ridx_q;
          otot_d   = placed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      placed_q <= '0;
      fail_q   <= '0;
      fin_q    <= 1'b0;
      ovalid_q <= 1'b0;
      bw_q     <= 32'd4194304;
      bh_q     <= 32'd4194304;
      cs_q     <= 32'd65536;
      ca_q     <= 7'd64;
      cd_q     <= 7'd64;
      dd_q     <= 32'd65536;
      tc_q     <= 13'd4096;
      al_q     <= 32'd1000000;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      placed_q <= placed_d;
      fail_q   <= fail_d;
      fin_q    <= fin_d;
      ovalid_q <= ovalid_d;
      if (cfg_ch.valid) begin
        case (cfg_reg_e'(cfg_ch.addr))
          REG_BOX_WIDTH:    bw_q <= cfg_ch.data;
          REG_BOX_HEIGHT:   bh_q <= cfg_ch.data;
          REG_CELL_SIZE:    cs_q <= cfg_ch.data;
          REG_CELLS_ACROSS: ca_q <= cfg_ch.data[CNT_CFG_W-1:0];
          REG_CELLS_DOWN:   cd_q <= cfg_ch.data[CNT_CFG_W-1:0];
          REG_DIAMETER:     dd_q <= cfg_ch.data;
          REG_TARGET:       tc_q <= cfg_ch.data[TGT_CFG_W-1:0];
          REG_ATTEMPTS:     al_q <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;  oidx_q <= oidx_d;  otot_q <= otot_d;
    rstat_q <= rstat_d;  ridx_q <= ridx_d;
    px_q <= px_d;  py_q <= py_d;  sy_q <= sy_d;  ax_q <= ax_d;  neg_q <= neg_d;
    nx_q <= nx_d;  ny_q <= ny_d;  cx_q <= cx_d;  cy_q <= cy_d;
    a_q <= a_d;  b_q <= b_d;  cell_q <= cell_d;  cnt_q <= cnt_d;  i_q <= i_d;
    ofill_q <= ofill_d;  diam2_q <= diam2_d;  sqx_q <= sqx_d;
  end

  assign in_ch.ready         = (state_q == ST_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ovalid_q;
  assign out_ch.status       = ostat_q;
  assign out_ch.disk_index   = DIDX_W'(oidx_q);
  assign out_ch.placed_total = TOTAL_W'(otot_q);

  `HDPCL_ASSERT(a_no_accept_in_clear, !(in_ch.ready && state_q == ST_CLEAR),
    "proposal taken during fill clearing pass")
  `HDPCL_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
    "ready stayed high after a proposal transaction")
  `HDPCL_ASSERT(a_placed_bound, 32'(placed_q) <= 32'(MAX_DISKS),
    "placed count beyond disk store depth")
  `HDPCL_ASSERT_NEXT(a_insert_clears_fail, state_q == ST_INSERT,
    fail_q == '0 && placed_q == $past(placed_q) + PC_W'(1),
    "placement did not bump count and clear failures")

endmodule
